FILE: sv/lscc_pkg.sv
package lscc_pkg;

    localparam int CMD_W       = 2;
    localparam int SECTOR_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int WAY_W       = 6;
    localparam int M_TDATA_W   = 40;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_READ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FULL = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_HIT   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [SECTOR_W-1:0] sector;
        logic                out_of_range;
    } req_t;

    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } back_state_t;

endpackage

FILE: sv/lru_sector_cache_controller.sv
// An in-range word at the queue head passes a lookup step (tag compare, lower victim tree)
// and then a resolve step; a new one is taken only once the last is resolved, as the
// lookup/update pair shares the tag, age and dirty registers. Out-of-range words skip both
// steps and pass at one per cycle; every result waits while the output is stalled.
// Reset (aresetn low, synchronous): entries invalid and clean, ages at ENTRIES,
// sector count 0, queue and output empty; tags are not cleared and need no sweep.
module lru_sector_cache_controller #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [lscc_pkg::SECTOR_W-1:0]   cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lscc_pkg::SECTOR_W-1:0]   s_tdata,  // sector[31:0]
    input  logic [lscc_pkg::CMD_W-1:0]      s_tuser,  // command[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lscc_pkg::M_TDATA_W-1:0]  m_tdata,  // way[5:0], writeback_needed[6],
                                                      // writeback_sector[38:7], fill_needed[39]
    output logic [lscc_pkg::STATUS_W-1:0]   m_tuser   // status[1:0]
);
    import lscc_pkg::*;

    req_t q_req;
    req_t q_head;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_head_valid;

    lscc_front #(
        .SECTOR_BITS (SECTOR_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_req     (q_req)
    );

    lscc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_req   (q_req),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    lscc_back #(
        .ENTRIES     (ENTRIES),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: sv/lscc_front.sv
module lscc_front #(
    parameter int SECTOR_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [lscc_pkg::SECTOR_W-1:0]  cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lscc_pkg::SECTOR_W-1:0]  s_tdata,
    input  logic [lscc_pkg::CMD_W-1:0]     s_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output lscc_pkg::req_t                 q_req
);
    import lscc_pkg::*;

    logic [SECTOR_W-1:0] sector_count_reg;
    logic                too_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_count_reg <= '0;
        end else if (cfg_wen) begin
            sector_count_reg <= cfg_wdata;
        end
    end

    assign too_wide = (s_tdata >> SECTOR_BITS) != '0;

    assign s_tready            = !q_full;
    assign q_push              = s_tvalid && !q_full;
    assign q_req.command       = s_tuser;
    assign q_req.sector        = s_tdata;
    assign q_req.out_of_range  = (s_tdata >= sector_count_reg) || too_wide;

endmodule

FILE: sv/lscc_queue.sv
module lscc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lscc_pkg::req_t  push_req,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output lscc_pkg::req_t  head
);
    import lscc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

FILE: sv/lscc_back.sv
module lscc_back #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  lscc_pkg::req_t                  head,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lscc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [lscc_pkg::STATUS_W-1:0]   m_tuser
);
    import lscc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int LEAVES = 1 << IDX_W;
    localparam int SPLIT  = IDX_W / 2;
    localparam int MID    = LEAVES >> SPLIT;
    localparam int AGE_W  = $clog2(ENTRIES + 1);
    localparam int TAG_W  = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [IDX_W-1:0] idx;
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } node_t;

    function automatic node_t pick_older(input node_t lo, input node_t hi);
        pick_older = (hi.age > lo.age) ? hi : lo;
    endfunction

    back_state_t state_reg;
    back_state_t state_next;

    logic [TAG_W-1:0]   tag_reg   [ENTRIES];
    logic [AGE_W-1:0]   age_reg   [ENTRIES];
    logic [AGE_W-1:0]   age_next  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [ENTRIES-1:0] dirty_reg;
    logic [ENTRIES-1:0] dirty_next;
    logic [ENTRIES-1:0] tag_we;

    logic [CMD_W-1:0]   cmd_reg;
    logic [TAG_W-1:0]   sector_reg;
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] match_now;
    node_t              mid_reg   [MID];
    node_t              low_tree  [LEAVES];
    node_t              high_tree [MID];
    node_t              victim;

    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic [AGE_W-1:0]   hit_age;
    logic               writes;
    logic               wb_needed;
    logic [SECTOR_W-1:0] wb_sector;
    logic [WAY_W-1:0]   way;
    logic               fill;

    logic               out_free;
    logic               load_lookup;
    logic               commit;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg;
    logic [STATUS_W-1:0]  m_tuser_next;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // lookup: tag compare and lower half of the victim tree
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_now[i] = valid_reg[i] && (tag_reg[i] == TAG_W'(head.sector));
        end
        for (int i = 0; i < LEAVES; i++) begin
            if (i < ENTRIES) begin
                low_tree[i].age   = age_reg[i];
                low_tree[i].idx   = IDX_W'(i);
                low_tree[i].valid = valid_reg[i];
                low_tree[i].dirty = dirty_reg[i];
                low_tree[i].tag   = tag_reg[i];
            end else begin
                low_tree[i] = '0;
            end
        end
        for (int lv = 0; lv < SPLIT; lv++) begin
            for (int j = 0; j < (LEAVES >> (lv + 1)); j++) begin
                low_tree[j] = pick_older(low_tree[2*j], low_tree[2*j+1]);
            end
        end
    end

    // resolve: upper half of the victim tree and hit decode
    always_comb begin
        for (int i = 0; i < MID; i++) begin
            high_tree[i] = mid_reg[i];
        end
        for (int lv = 0; lv < IDX_W - SPLIT; lv++) begin
            for (int j = 0; j < (MID >> (lv + 1)); j++) begin
                high_tree[j] = pick_older(high_tree[2*j], high_tree[2*j+1]);
            end
        end
        victim = high_tree[0];

        hit_any = |match_reg;
        hit_idx = '0;
        hit_age = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_reg[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
                hit_age = hit_age | age_reg[i];
            end
        end
    end

    assign writes    = cmd_reg != CMD_READ;
    assign wb_needed = !hit_any && victim.valid && victim.dirty;
    assign wb_sector = wb_needed ? SECTOR_W'(victim.tag) : '0;
    assign way       = hit_any ? WAY_W'(hit_idx) : WAY_W'(victim.idx);
    assign fill      = !hit_any && (cmd_reg != CMD_FULL);

    always_comb begin
        state_next    = state_reg;
        pop           = 1'b0;
        load_lookup   = 1'b0;
        commit        = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            S_IDLE: begin
                if (head_valid) begin
                    if (head.out_of_range) begin
                        if (out_free) begin
                            pop           = 1'b1;
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = STATUS_RANGE;
                            m_tdata_next  = '0;
                        end
                    end else begin
                        pop         = 1'b1;
                        load_lookup = 1'b1;
                        state_next  = S_RESOLVE;
                    end
                end
            end
            S_RESOLVE: begin
                if (out_free) begin
                    commit        = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = hit_any ? STATUS_HIT : STATUS_MISS;
                    m_tdata_next  = {fill, wb_sector, wb_needed, way};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            age_next[i]   = age_reg[i];
            valid_next[i] = valid_reg[i];
            dirty_next[i] = dirty_reg[i];
            tag_we[i]     = 1'b0;
            if (commit) begin
                if (hit_any) begin
                    if (age_reg[i] < hit_age) begin
                        age_next[i] = age_reg[i] + AGE_W'(1);
                    end
                    if (match_reg[i]) begin
                        age_next[i] = '0;
                        if (writes) begin
                            dirty_next[i] = 1'b1;
                        end
                    end
                end else begin
                    if (age_reg[i] < AGE_W'(ENTRIES)) begin
                        age_next[i] = age_reg[i] + AGE_W'(1);
                    end
                    if (victim.idx == IDX_W'(i)) begin
                        age_next[i]   = '0;
                        dirty_next[i] = writes;
                        valid_next[i] = 1'b1;
                        tag_we[i]     = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                age_reg[i] <= AGE_W'(ENTRIES);
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            for (int i = 0; i < ENTRIES; i++) begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (load_lookup) begin
            cmd_reg    <= head.command;
            sector_reg <= TAG_W'(head.sector);
            match_reg  <= match_now;
            for (int i = 0; i < MID; i++) begin
                mid_reg[i] <= low_tree[i];
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (tag_we[i]) begin
                tag_reg[i] <= sector_reg;
            end
        end
    end

`ifndef SYNTH
    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESOLVE |-> $onehot0(match_reg))
        else $error("more than one entry matches the sector");

    a_resolve_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESOLVE && out_free) |=>
            (m_tvalid_reg && m_tuser_reg != STATUS_RANGE))
        else $error("lookup finished without a hit or miss word");

    a_valid_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESOLVE && out_free) |=>
            ($countones(valid_reg) >= $past($countones(valid_reg))))
        else $error("an entry lost its valid bit");
`endif

endmodule
